// ===== rtl/core/rhc_pkg.sv =====
// shared types and constants for the rgb to hsv converter
// no dependencies; every other file in rtl/core refers to it by scoped name
`default_nettype none

package rhc_pkg;

   // hue is degrees times 64
   localparam int HUE_BITS      = 15;
   // a hue quotient never exceeds one sector
   localparam int HUE_Q_BITS    = 12;
   // signed working width for offset, sign and wrap
   localparam int HUE_CALC_BITS = 16;

   localparam int HUE_SECTOR    = 3840;
   localparam int HUE_FULL      = 23040;
   localparam int HUE_OFF_GREEN = 2 * HUE_SECTOR;
   localparam int HUE_OFF_BLUE  = 4 * HUE_SECTOR;

   // 3840 is 4096 minus 256
   localparam int HUE_SECTOR_HI_SHIFT = 12;
   localparam int HUE_SECTOR_LO_SHIFT = 8;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } rhc_sector_type;

   // per-pixel flags that ride along the divider chain
   typedef struct packed {
      rhc_sector_type sector;
      logic           negative;
      logic           undefined;
   } rhc_tag_type;

endpackage

`default_nettype wire

// ===== rtl/core/rhc_stream_if.sv =====
// valid/ready stream interfaces for pixel requests and hsv responses
// depends on rhc_pkg for the hue width
`default_nettype none

interface rhc_req_if #(parameter int COMPONENT_BITS = 8) ();
   logic                      valid;
   logic                      ready;
   logic [COMPONENT_BITS-1:0] red;
   logic [COMPONENT_BITS-1:0] green;
   logic [COMPONENT_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_rsp_if #(parameter int COMPONENT_BITS = 8) ();
   logic                          valid;
   logic                          ready;
   logic [rhc_pkg::HUE_BITS-1:0]  hue;
   logic [COMPONENT_BITS-1:0]     saturation;
   logic [COMPONENT_BITS-1:0]     brightness;
   logic                          hue_undefined;

   modport source (output valid, output hue, output saturation, output brightness,
                   output hue_undefined, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input hue_undefined, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rhc_prep.sv =====
// front stage: max, min, sector, difference and both dividends, registered
// depends on rhc_pkg and rhc_req_if
`default_nettype none

module rhc_prep #(
   parameter int COMPONENT_BITS = 8,
   parameter int STEPS          = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   rhc_req_if.sink                          req_chan,
   output logic                             down_valid,
   input  wire logic                        down_ready,
   output logic [COMPONENT_BITS+STEPS-1:0]  down_sat_rem,
   output logic [COMPONENT_BITS+STEPS-1:0]  down_hue_rem,
   output logic [COMPONENT_BITS-1:0]        down_brightness,
   output logic [COMPONENT_BITS-1:0]        down_delta,
   output rhc_pkg::rhc_tag_type             down_tag
);

   localparam int N    = COMPONENT_BITS;
   localparam int WIDE = COMPONENT_BITS + STEPS;

   logic                  valid_ff;
   logic                  take;
   logic [N-1:0]          mx, mn, mn_rg, minuend, subtrahend, delta, mag;
   logic                  red_top, green_top, neg;
   rhc_pkg::rhc_sector_type sector;
   logic [WIDE-1:0]       sat_rem_in, hue_rem_in;
   rhc_pkg::rhc_tag_type  tag_in;
   logic [WIDE-1:0]       sat_rem_ff, hue_rem_ff;
   logic [N-1:0]          brightness_ff, delta_ff;
   rhc_pkg::rhc_tag_type  tag_ff;

   assign req_chan.ready = !valid_ff || down_ready;
   assign take           = req_chan.valid && req_chan.ready;

   // ties go to red, then green
   assign red_top   = (req_chan.red >= req_chan.green) && (req_chan.red >= req_chan.blue);
   assign green_top = !red_top && (req_chan.green >= req_chan.blue);

   always_comb begin
      if (red_top) begin
         sector     = rhc_pkg::SECTOR_RED;
         mx         = req_chan.red;
         minuend    = req_chan.green;
         subtrahend = req_chan.blue;
      end else if (green_top) begin
         sector     = rhc_pkg::SECTOR_GREEN;
         mx         = req_chan.green;
         minuend    = req_chan.blue;
         subtrahend = req_chan.red;
      end else begin
         sector     = rhc_pkg::SECTOR_BLUE;
         mx         = req_chan.blue;
         minuend    = req_chan.red;
         subtrahend = req_chan.green;
      end
   end

   assign mn_rg = (req_chan.red < req_chan.green) ? req_chan.red : req_chan.green;
   assign mn    = (mn_rg < req_chan.blue) ? mn_rg : req_chan.blue;
   assign delta = mx - mn;

   // magnitude and sign of the difference, so the quotient truncates toward zero
   assign neg = minuend < subtrahend;
   assign mag = neg ? (subtrahend - minuend) : (minuend - subtrahend);

   // delta times full scale, and magnitude times one sector
   assign sat_rem_in = (WIDE'(delta) << N) - WIDE'(delta);
   assign hue_rem_in = (WIDE'(mag) << rhc_pkg::HUE_SECTOR_HI_SHIFT)
                     - (WIDE'(mag) << rhc_pkg::HUE_SECTOR_LO_SHIFT);

   always_comb begin
      tag_in.sector    = sector;
      tag_in.negative  = neg;
      tag_in.undefined = (delta == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sat_rem_ff    <= sat_rem_in;
         hue_rem_ff    <= hue_rem_in;
         brightness_ff <= mx;
         delta_ff      <= delta;
         tag_ff        <= tag_in;
      end
   end

   assign down_valid      = valid_ff;
   assign down_sat_rem    = sat_rem_ff;
   assign down_hue_rem    = hue_rem_ff;
   assign down_brightness = brightness_ff;
   assign down_delta      = delta_ff;
   assign down_tag        = tag_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rhc_div_cell.sv =====
// one restoring-division cell: settles one quotient bit of both divisions
// depends on rhc_pkg for the tag type
`default_nettype none

module rhc_div_cell #(
   parameter int COMPONENT_BITS = 8,
   parameter int STEPS          = 12,
   parameter int BIT            = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              up_valid,
   output logic                                   up_ready,
   input  wire logic [COMPONENT_BITS+STEPS-1:0]   up_sat_rem,
   input  wire logic [COMPONENT_BITS+STEPS-1:0]   up_hue_rem,
   input  wire logic [STEPS-1:0]                  up_sat_q,
   input  wire logic [STEPS-1:0]                  up_hue_q,
   input  wire logic [COMPONENT_BITS-1:0]         up_brightness,
   input  wire logic [COMPONENT_BITS-1:0]         up_delta,
   input  wire rhc_pkg::rhc_tag_type              up_tag,
   output logic                                   down_valid,
   input  wire logic                              down_ready,
   output logic [COMPONENT_BITS+STEPS-1:0]        down_sat_rem,
   output logic [COMPONENT_BITS+STEPS-1:0]        down_hue_rem,
   output logic [STEPS-1:0]                       down_sat_q,
   output logic [STEPS-1:0]                       down_hue_q,
   output logic [COMPONENT_BITS-1:0]              down_brightness,
   output logic [COMPONENT_BITS-1:0]              down_delta,
   output rhc_pkg::rhc_tag_type                   down_tag
);

   localparam int WIDE = COMPONENT_BITS + STEPS;

   logic                 valid_ff;
   logic                 take;
   logic [WIDE:0]        sat_trial, hue_trial;
   logic [WIDE-1:0]      sat_rem_in, hue_rem_in;
   logic [STEPS-1:0]     sat_q_in, hue_q_in;
   logic [WIDE-1:0]      sat_rem_ff, hue_rem_ff;
   logic [STEPS-1:0]     sat_q_ff, hue_q_ff;
   logic [COMPONENT_BITS-1:0] brightness_ff, delta_ff;
   rhc_pkg::rhc_tag_type tag_ff;

   assign up_ready = !valid_ff || down_ready;
   assign take     = up_valid && up_ready;

   // saturation divides by the maximum, hue by delta
   assign sat_trial = {1'b0, up_sat_rem} - {1'b0, WIDE'(up_brightness) << BIT};
   assign hue_trial = {1'b0, up_hue_rem} - {1'b0, WIDE'(up_delta) << BIT};

   always_comb begin
      sat_q_in   = up_sat_q;
      hue_q_in   = up_hue_q;
      sat_rem_in = up_sat_rem;
      hue_rem_in = up_hue_rem;
      if (!sat_trial[WIDE]) begin
         sat_q_in[BIT] = 1'b1;
         sat_rem_in    = sat_trial[WIDE-1:0];
      end
      if (!hue_trial[WIDE]) begin
         hue_q_in[BIT] = 1'b1;
         hue_rem_in    = hue_trial[WIDE-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sat_rem_ff    <= sat_rem_in;
         hue_rem_ff    <= hue_rem_in;
         sat_q_ff      <= sat_q_in;
         hue_q_ff      <= hue_q_in;
         brightness_ff <= up_brightness;
         delta_ff      <= up_delta;
         tag_ff        <= up_tag;
      end
   end

   assign down_valid      = valid_ff;
   assign down_sat_rem    = sat_rem_ff;
   assign down_hue_rem    = hue_rem_ff;
   assign down_sat_q      = sat_q_ff;
   assign down_hue_q      = hue_q_ff;
   assign down_brightness = brightness_ff;
   assign down_delta      = delta_ff;
   assign down_tag        = tag_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rhc_finish.sv =====
// back stage: sign, sector offset and wrap of hue, then the output register
// depends on rhc_pkg and rhc_rsp_if
`default_nettype none

module rhc_finish #(
   parameter int COMPONENT_BITS = 8,
   parameter int STEPS          = 12
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        up_valid,
   output logic                             up_ready,
   input  wire logic [STEPS-1:0]            up_sat_q,
   input  wire logic [STEPS-1:0]            up_hue_q,
   input  wire logic [COMPONENT_BITS-1:0]   up_brightness,
   input  wire rhc_pkg::rhc_tag_type        up_tag,
   rhc_rsp_if.source                        rsp_chan
);

   localparam int CB = rhc_pkg::HUE_CALC_BITS;
   localparam int HB = rhc_pkg::HUE_BITS;
   localparam int QB = rhc_pkg::HUE_Q_BITS;

   logic                       valid_ff;
   logic                       take;
   logic signed [CB-1:0]       offset, signed_q, raw, wrapped;
   logic [HB-1:0]              hue_in, hue_ff;
   logic [COMPONENT_BITS-1:0]  sat_in, sat_ff, brightness_ff;
   logic                       undefined_ff;

   assign up_ready = !valid_ff || rsp_chan.ready;
   assign take     = up_valid && up_ready;

   always_comb begin
      case (up_tag.sector)
         rhc_pkg::SECTOR_RED:   offset = '0;
         rhc_pkg::SECTOR_GREEN: offset = CB'(rhc_pkg::HUE_OFF_GREEN);
         rhc_pkg::SECTOR_BLUE:  offset = CB'(rhc_pkg::HUE_OFF_BLUE);
         default:               offset = '0;
      endcase
   end

   assign signed_q = up_tag.negative ? -$signed(CB'(up_hue_q[QB-1:0]))
                                     :  $signed(CB'(up_hue_q[QB-1:0]));
   assign raw      = offset + signed_q;
   // negative hue wraps round by a full turn
   assign wrapped  = raw[CB-1] ? (raw + CB'(rhc_pkg::HUE_FULL)) : raw;
   assign hue_in   = up_tag.undefined ? '0 : wrapped[HB-1:0];
   assign sat_in   = up_tag.undefined ? '0 : up_sat_q[COMPONENT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hue_ff        <= hue_in;
         sat_ff        <= sat_in;
         brightness_ff <= up_brightness;
         undefined_ff  <= up_tag.undefined;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.hue           = hue_ff;
   assign rsp_chan.saturation    = sat_ff;
   assign rsp_chan.brightness    = brightness_ff;
   assign rsp_chan.hue_undefined = undefined_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_converter_core.sv =====
// rgb to hsv converter core: front stage, chain of division cells, back stage
// depends on rhc_pkg, rhc_stream_if, rhc_prep, rhc_div_cell and rhc_finish
//
// usage
//   req_chan carries one pixel per transfer (red, green, blue, unsigned).
//   rsp_chan returns one hsv result per pixel, in order: hue in degrees
//   times 64, saturation scaled to full scale, brightness (largest
//   component) and hue_undefined when all three components are equal.
//   between its request transfer and its response, a pixel passes STEPS + 2
//   registers: one front stage, one division cell per quotient bit, one output
//   stage, where STEPS is the larger of 12 and COMPONENT_BITS.
//   throughput is one pixel per cycle unless the receiver stalls; each cell
//   settles one quotient bit of both the saturation and hue division and hands it on.
//   every stage has its own valid flag and its ready is "empty or the next
//   stage moves", so bubbles close up and requests are still taken while a
//   response waits; a stalled receiver fills the chain, which then holds
//   STEPS + 2 pixels before req_chan.ready falls.
//   reset clears all stage valid flags; data registers are not reset.
`default_nettype none

module rgb_to_hsv_converter_core #(
   parameter int COMPONENT_BITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rhc_req_if.sink     req_chan,
   rhc_rsp_if.source   rsp_chan
);

   // enough quotient bits for both divisions
   localparam int STEPS = (COMPONENT_BITS > rhc_pkg::HUE_Q_BITS) ? COMPONENT_BITS
                                                                 : rhc_pkg::HUE_Q_BITS;
   localparam int WIDE  = COMPONENT_BITS + STEPS;

   // chain taps: index 0 leaves the front stage, index STEPS enters the back stage
   logic                       chain_valid [0:STEPS];
   logic                       chain_ready [0:STEPS];
   logic [WIDE-1:0]            chain_sat_rem [0:STEPS];
   logic [WIDE-1:0]            chain_hue_rem [0:STEPS];
   logic [STEPS-1:0]           chain_sat_q [0:STEPS];
   logic [STEPS-1:0]           chain_hue_q [0:STEPS];
   logic [COMPONENT_BITS-1:0]  chain_brightness [0:STEPS];
   logic [COMPONENT_BITS-1:0]  chain_delta [0:STEPS];
   rhc_pkg::rhc_tag_type       chain_tag [0:STEPS];

   rhc_prep #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .STEPS          (STEPS)
   ) u_prep (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .down_valid      (chain_valid[0]),
      .down_ready      (chain_ready[0]),
      .down_sat_rem    (chain_sat_rem[0]),
      .down_hue_rem    (chain_hue_rem[0]),
      .down_brightness (chain_brightness[0]),
      .down_delta      (chain_delta[0]),
      .down_tag        (chain_tag[0])
   );

   // quotients start empty and fill one bit per cell
   assign chain_sat_q[0] = '0;
   assign chain_hue_q[0] = '0;

   // cell g settles quotient bit STEPS-1-g, most significant first
   for (genvar g = 0; g < STEPS; g++) begin : g_cell
      rhc_div_cell #(
         .COMPONENT_BITS (COMPONENT_BITS),
         .STEPS          (STEPS),
         .BIT            (STEPS - 1 - g)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .up_valid        (chain_valid[g]),
         .up_ready        (chain_ready[g]),
         .up_sat_rem      (chain_sat_rem[g]),
         .up_hue_rem      (chain_hue_rem[g]),
         .up_sat_q        (chain_sat_q[g]),
         .up_hue_q        (chain_hue_q[g]),
         .up_brightness   (chain_brightness[g]),
         .up_delta        (chain_delta[g]),
         .up_tag          (chain_tag[g]),
         .down_valid      (chain_valid[g+1]),
         .down_ready      (chain_ready[g+1]),
         .down_sat_rem    (chain_sat_rem[g+1]),
         .down_hue_rem    (chain_hue_rem[g+1]),
         .down_sat_q      (chain_sat_q[g+1]),
         .down_hue_q      (chain_hue_q[g+1]),
         .down_brightness (chain_brightness[g+1]),
         .down_delta      (chain_delta[g+1]),
         .down_tag        (chain_tag[g+1])
      );
   end

   // final remainders and delta are spent; only quotients, brightness and tag go on
   rhc_finish #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .STEPS          (STEPS)
   ) u_finish (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (chain_valid[STEPS]),
      .up_ready      (chain_ready[STEPS]),
      .up_sat_q      (chain_sat_q[STEPS]),
      .up_hue_q      (chain_hue_q[STEPS]),
      .up_brightness (chain_brightness[STEPS]),
      .up_tag        (chain_tag[STEPS]),
      .rsp_chan      (rsp_chan)
   );

   // hue always lies within one full turn
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.hue < rhc_pkg::HUE_BITS'(rhc_pkg::HUE_FULL)))
      else $error("hue beyond a full turn");

   // grey pixels give zero hue and zero saturation
   a_grey_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.hue_undefined) |->
         (rsp_chan.hue == '0 && rsp_chan.saturation == '0))
      else $error("undefined hue with non-zero hue or saturation");

   // a coloured pixel has a non-zero maximum and saturation of at least one step
   a_colour_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.hue_undefined) |->
         (rsp_chan.saturation != '0 && rsp_chan.brightness != '0))
      else $error("coloured pixel with zero saturation or brightness");

   // the front stage only refuses a transfer while it is holding a pixel
   a_prep_ready : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> chain_valid[0])
      else $error("request refused with empty front stage");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for rgb_to_hsv_converter_core: directed table, then random pixels
// depends on rhc_pkg and the stream interfaces in rhc_stream_if; hsv results are predicted here

module tb_top;

   localparam int COMP_BITS      = 8;
   localparam int FULL_SCALE     = (1 << COMP_BITS) - 1;
   localparam int HUE_W          = rhc_pkg::HUE_BITS;
   // hue arithmetic in degrees times 64
   localparam int DEG60          = 3840;
   localparam int DEG360         = 23040;
   localparam int OFFSET_GREEN   = 2 * DEG60;
   localparam int OFFSET_BLUE    = 4 * DEG60;
   // pipeline is 14 registers deep at 8 bits, output stage included
   localparam int SETTLE_CYCLES  = 24;
   localparam int IDLE_LIMIT     = 1000;
   localparam int LONG_HOLD      = 80;
   localparam int HOLD_ITEMS     = 60;
   localparam int BLOCK_ITEMS    = 40;
   localparam int RANDOM_BLOCKS  = 27;
   localparam int DIRECTED_COUNT = 25;

   typedef logic [COMP_BITS-1:0] comp_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      comp_type         saturation;
      comp_type         brightness;
      logic             hue_undefined;
   } hsv_type;

   // typed set: expectation written into the row; otherwise predicted
   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
      bit       typed;
      hsv_type  want;
   } pixel_row_type;

   logic clock;
   logic reset;

   rhc_req_if #(.COMPONENT_BITS(COMP_BITS)) req_chan ();
   rhc_rsp_if #(.COMPONENT_BITS(COMP_BITS)) rsp_chan ();

   rgb_to_hsv_converter_core #(
      .COMPONENT_BITS(COMP_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   hsv_type pending_hsv [$];
   int   mismatch_count = 0;
   int   idle_cycles    = 0;
   bit   req_quiet      = 1'b0;
   bit   rsp_quiet      = 1'b0;
   bit   rsp_hold_pending = 1'b0;

   // directed table: extremes, grey levels, every sector, ties and hue wrap-round
   pixel_row_type directed_rows [DIRECTED_COUNT] = '{
      // black, white and mid grey: hue undefined
      '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd0,   8'd0,   1'b1}},
      '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     8'd0,   8'd255, 1'b1}},
      '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     8'd0,   8'd128, 1'b1}},
      // pure primaries, one per sector
      '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd255, 1'b0}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  8'd255, 8'd255, 1'b0}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 8'd255, 8'd255, 1'b0}},
      // red beats green on a tie, green beats blue
      '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  8'd255, 8'd255, 1'b0}},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 8'd255, 8'd255, 1'b0}},
      // magenta: negative hue wraps by a full turn
      '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 8'd255, 8'd255, 1'b0}},
      '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd1,   1'b0}},
      '{8'd0,   8'd1,   8'd1,   1'b1, '{15'd11520, 8'd255, 8'd1,   1'b0}},
      // remaining rows go through the predictor
      '{8'd255, 8'd0,   8'd1,   1'b0, '0},
      '{8'd255, 8'd254, 8'd254, 1'b0, '0},
      '{8'd254, 8'd255, 8'd255, 1'b0, '0},
      '{8'd1,   8'd1,   8'd0,   1'b0, '0},
      '{8'hAA,  8'h55,  8'h0F,  1'b0, '0},
      '{8'h55,  8'hAA,  8'hF0,  1'b0, '0},
      '{8'h0F,  8'hF0,  8'h33,  1'b0, '0},
      '{8'd200, 8'd100, 8'd150, 1'b0, '0},
      '{8'd100, 8'd200, 8'd250, 1'b0, '0},
      '{8'd250, 8'd10,  8'd20,  1'b0, '0},
      '{8'd1,   8'd2,   8'd3,   1'b0, '0},
      '{8'd254, 8'd1,   8'd255, 1'b0, '0},
      '{8'd127, 8'd128, 8'd129, 1'b0, '0},
      '{8'd128, 8'd127, 8'd126, 1'b0, '0}
   };

   // free-running clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // expected hsv for one pixel
   function automatic hsv_type hsv_of_pixel(input comp_type r, input comp_type g,
                                            input comp_type b);
      int unsigned peak;
      int unsigned floor_val;
      int unsigned spread;
      int          diff;
      int          offset;
      int          hue_acc;
      hsv_type     res;
      peak = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;
      floor_val = r;
      if (g < floor_val) floor_val = g;
      if (b < floor_val) floor_val = b;
      spread = peak - floor_val;
      res = '0;
      res.brightness = comp_type'(peak);
      if (spread == 0) begin
         res.hue_undefined = 1'b1;
      end else begin
         res.saturation = comp_type'((spread * FULL_SCALE) / peak);
         // sector chosen in red, green, blue order so ties go to the earlier one
         if (r == peak) begin
            diff   = int'(g) - int'(b);
            offset = 0;
         end else if (g == peak) begin
            diff   = int'(b) - int'(r);
            offset = OFFSET_GREEN;
         end else begin
            diff   = int'(r) - int'(g);
            offset = OFFSET_BLUE;
         end
         // signed division truncates toward zero
         hue_acc = (diff * DEG60) / int'(spread) + offset;
         if (hue_acc < 0) hue_acc += DEG360;
         res.hue = hue_acc[HUE_W-1:0];
      end
      return res;
   endfunction

   // offer one pixel after a random gap and wait for its transfer
   task automatic send_pixel(input comp_type r, input comp_type g, input comp_type b,
                             input bit typed, input hsv_type want);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.red   <= r;
      req_chan.green <= g;
      req_chan.blue  <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // transfer happened at this edge
      pending_hsv.push_back(typed ? want : hsv_of_pixel(r, g, b));
   endtask

   // random pixel, biased towards greys, ties, near-greys and extremes
   task automatic send_random_pixel();
      comp_type r;
      comp_type g;
      comp_type b;
      comp_type base;
      int       kind;
      kind = $urandom_range(0, 9);
      base = comp_type'($urandom_range(0, FULL_SCALE));
      r    = comp_type'($urandom);
      g    = comp_type'($urandom);
      b    = comp_type'($urandom);
      case (kind)
         5: begin
            // grey level, hue undefined
            r = base;
            g = base;
            b = base;
         end
         6: begin
            // two components equal
            case ($urandom_range(0, 2))
               0: g = r;
               1: b = g;
               default: b = r;
            endcase
         end
         7: begin
            // very small spread around a grey level
            r = base;
            g = base ^ comp_type'($urandom_range(0, 1));
            b = base ^ comp_type'($urandom_range(0, 3));
         end
         8: begin
            // push components to all-zeros or all-ones
            if ($urandom_range(0, 1)) r = {COMP_BITS{r[0]}};
            if ($urandom_range(0, 1)) g = {COMP_BITS{g[0]}};
            if ($urandom_range(0, 1)) b = {COMP_BITS{b[0]}};
         end
         default: begin
         end
      endcase
      send_pixel(r, g, b, 1'b0, '0);
   endtask

   // sender stops offering and waits for every outstanding result
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_hsv.size() != 0) @(posedge clock);
   endtask

   // stimulus and end of run
   initial begin : stimulus
      req_chan.valid <= 1'b0;
      req_chan.red   <= '0;
      req_chan.green <= '0;
      req_chan.blue  <= '0;
      reset          <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                    directed_rows[i].typed, directed_rows[i].want);
      end

      // sender pause until the pipeline is empty
      wait_drained();

      // receiver holds off while pixels keep coming back to back: the chain fills
      rsp_hold_pending = 1'b1;
      req_quiet        = 1'b1;
      repeat (HOLD_ITEMS) send_random_pixel();

      // random pixels in blocks, some blocks with no gaps at all
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         req_quiet = ($urandom_range(0, 2) == 0);
         repeat (BLOCK_ITEMS) send_random_pixel();
      end

      wait_drained();
      // let a stray extra result show up, if any
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result receiver: random stalls per transfer, quiet stretches, one long hold-off
   initial begin : rsp_drain
      int stall;
      int served;
      served = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (served % 50 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
         stall = rsp_quiet ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         served++;
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      hsv_type got;
      hsv_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.hue           = rsp_chan.hue;
         got.saturation    = rsp_chan.saturation;
         got.brightness    = rsp_chan.brightness;
         got.hue_undefined = rsp_chan.hue_undefined;
         if (pending_hsv.size() == 0) begin
            $error("result with no pixel outstanding: hue %0d", got.hue);
            mismatch_count++;
         end else begin
            want = pending_hsv.pop_front();
            if (got.hue !== want.hue) begin
               $error("hue: expected %0d, actual %0d", want.hue, got.hue);
               mismatch_count++;
            end
            if (got.saturation !== want.saturation) begin
               $error("saturation: expected %0d, actual %0d", want.saturation,
                      got.saturation);
               mismatch_count++;
            end
            if (got.brightness !== want.brightness) begin
               $error("brightness: expected %0d, actual %0d", want.brightness,
                      got.brightness);
               mismatch_count++;
            end
            if (got.hue_undefined !== want.hue_undefined) begin
               $error("hue_undefined: expected %0d, actual %0d", want.hue_undefined,
                      got.hue_undefined);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: too long without any transfer on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
